>>> src/pmx_pkg.sv
// ----------------------------------------------------------------------------
// PMX package
// Field layout of the request and response streams and the item kind codes
// of the partially matched crossover block.
// ----------------------------------------------------------------------------
`default_nettype none

package pmx_pkg;

   // Fixed field widths of the stream items.
   localparam int GENE_BITS = 8;
   localparam int CUT_BITS  = 5;
   localparam int POS_BITS  = 5;

   // Request tdata: parent1_gene, parent2_gene, cut_first, cut_second.
   localparam int REQ_P1_LSB    = 0;
   localparam int REQ_P2_LSB    = REQ_P1_LSB + GENE_BITS;
   localparam int REQ_CUTA_LSB  = REQ_P2_LSB + GENE_BITS;
   localparam int REQ_CUTB_LSB  = REQ_CUTA_LSB + CUT_BITS;
   localparam int REQ_USED_BITS = REQ_CUTB_LSB + CUT_BITS;
   localparam int REQ_DATA_BITS = ((REQ_USED_BITS + 7) / 8) * 8;

   // Response tdata: child1_gene, child2_gene, position.
   localparam int RSP_C1_LSB    = 0;
   localparam int RSP_C2_LSB    = RSP_C1_LSB + GENE_BITS;
   localparam int RSP_POS_LSB   = RSP_C2_LSB + GENE_BITS;
   localparam int RSP_USED_BITS = RSP_POS_LSB + POS_BITS;
   localparam int RSP_DATA_BITS = ((RSP_USED_BITS + 7) / 8) * 8;

   // Item kinds carried in req_tuser.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_RUN  = 1'b1;

endpackage

`default_nettype wire

>>> src/pmx_ram.sv
// ----------------------------------------------------------------------------
// PMX generic RAM
// One write port and one read port with a registered, enabled read. A read
// of the entry being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module pmx_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/partially_matched_crossover.sv
// ----------------------------------------------------------------------------
// Partially matched crossover
// Loads two parent gene vectors pair by pair, then on a run item builds both
// children by PMX between two cut points and streams them out pair by pair.
//
//   channel | direction | tdata (low bit up)                        | tuser | tlast
//   req_    | in        | parent1_gene, parent2_gene, cut_first,    | kind  | last_gene
//           |           | cut_second                                |       |
//   rsp_    | out       | child1_gene, child2_gene, position        | -     | last_result
//
// A load item leaves the block idle and ready for the next one. A run item
// fetches and latches the parent pair at each position between the cuts and
// sweeps all loaded positions with it, then the children are read out through
// the single read port of the child memory, one gene pair per cycle when the
// sink does not stall. req_tready is low while a run is in progress. Reset is
// synchronous and clears the load state; the memories keep their contents. A
// stalled result holds in the output register and pauses the read-out.
// ----------------------------------------------------------------------------
`default_nettype none

module partially_matched_crossover #(
   parameter int GENE_COUNT = 32,
   parameter int VALUE_BITS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // parent1_gene[7:0], parent2_gene[15:8], cut_first[20:16], cut_second[25:21]
   input  wire logic [pmx_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // kind
   input  wire logic                               req_tuser,
   input  wire logic                               req_tlast,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // child1_gene[7:0], child2_gene[15:8], position[20:16]
   output logic      [pmx_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                    rsp_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready
);

   localparam int AW = $clog2(GENE_COUNT);
   localparam int CW = $clog2(GENE_COUNT + 1);
   localparam int MW = (CW > pmx_pkg::CUT_BITS) ? CW : pmx_pkg::CUT_BITS;
   localparam int VW = VALUE_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LATCH,
      ST_SWEEP,
      ST_FLUSH,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic          closed_ff, closed_in;
   logic [AW-1:0] len_m1_ff, len_m1_in;
   logic [AW-1:0] j_ff, j_in;
   logic [AW-1:0] hi_ff, hi_in;
   logic [AW-1:0] k_ff, k_in;
   logic          first_pass_ff, first_pass_in;
   logic [VW-1:0] p1_ff, p1_in;
   logic [VW-1:0] p2_ff, p2_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic          pend_src_ff, pend_src_in;
   logic          dvalid_ff, dvalid_in;
   logic [AW-1:0] dpos_ff, dpos_in;
   logic          rd_done_ff, rd_done_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [pmx_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // Memory ports: parents and children each packed as {second, first}.
   logic            par_wr_en;
   logic [AW-1:0]   par_wr_addr;
   logic [2*VW-1:0] par_wr_data;
   logic            par_rd_en;
   logic [AW-1:0]   par_rd_addr;
   logic [2*VW-1:0] par_rd_data;
   logic            chd_wr_en;
   logic [2*VW-1:0] chd_wr_data;
   logic            chd_rd_en;
   logic [AW-1:0]   chd_rd_addr;
   logic [2*VW-1:0] chd_rd_data;

   logic [2*VW-1:0] src_word;
   logic [CW-1:0]   cnt_eff;
   logic [pmx_pkg::CUT_BITS-1:0] cut_a, cut_b;
   logic [MW-1:0]   lo_w, hi_w, lim_w;
   logic            take, issue;

   function automatic logic [VW-1:0] remap(input logic [VW-1:0] g,
                                            input logic [VW-1:0] from_v,
                                            input logic [VW-1:0] to_v);
      logic [VW-1:0] r;
      r = g;
      if (g == from_v) begin
         r = to_v;
      end else if (g == to_v) begin
         r = from_v;
      end
      return r;
   endfunction

   pmx_ram #(.WIDTH(2 * VW), .DEPTH(GENE_COUNT)) u_parent_ram (
      .clock   (clock),
      .wr_en   (par_wr_en),
      .wr_addr (par_wr_addr),
      .wr_data (par_wr_data),
      .rd_en   (par_rd_en),
      .rd_addr (par_rd_addr),
      .rd_data (par_rd_data)
   );

   pmx_ram #(.WIDTH(2 * VW), .DEPTH(GENE_COUNT)) u_child_ram (
      .clock   (clock),
      .wr_en   (chd_wr_en),
      .wr_addr (pend_addr_ff),
      .wr_data (chd_wr_data),
      .rd_en   (chd_rd_en),
      .rd_addr (chd_rd_addr),
      .rd_data (chd_rd_data)
   );

   // Write-back half of the sweep: the entry read last cycle is remapped and
   // stored. The first pass reads the parents, so no copy step is needed.
   assign src_word    = pend_src_ff ? par_rd_data : chd_rd_data;
   assign chd_wr_en   = pend_ff;
   assign chd_wr_data = {remap(src_word[2*VW-1:VW], p1_ff, p2_ff),
                         remap(src_word[VW-1:0], p1_ff, p2_ff)};

   assign cut_a   = req_tdata[pmx_pkg::REQ_CUTA_LSB +: pmx_pkg::CUT_BITS];
   assign cut_b   = req_tdata[pmx_pkg::REQ_CUTB_LSB +: pmx_pkg::CUT_BITS];
   assign cnt_eff = closed_ff ? '0 : count_ff;
   assign lim_w   = MW'(count_ff) - MW'(1);

   always_comb begin
      lo_w = (cut_a > cut_b) ? MW'(cut_b) : MW'(cut_a);
      hi_w = (cut_a > cut_b) ? MW'(cut_a) : MW'(cut_b);
      if (lo_w > lim_w) begin
         lo_w = lim_w;
      end
      if (hi_w > lim_w) begin
         hi_w = lim_w;
      end
   end

   assign take  = (state_ff == ST_EMIT) && dvalid_ff && (!rsp_valid_ff || rsp_tready);
   assign issue = (state_ff == ST_EMIT) && !rd_done_ff && (!dvalid_ff || take);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      closed_in     = closed_ff;
      len_m1_in     = len_m1_ff;
      j_in          = j_ff;
      hi_in         = hi_ff;
      k_in          = k_ff;
      first_pass_in = first_pass_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pend_src_in   = pend_src_ff;
      dvalid_in     = dvalid_ff;
      dpos_in       = dpos_ff;
      rd_done_in    = rd_done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_last_in   = rsp_last_ff;
      rsp_data_in   = rsp_data_ff;

      par_wr_en   = 1'b0;
      par_wr_addr = AW'(cnt_eff);
      par_wr_data = {VW'(req_tdata[pmx_pkg::REQ_P2_LSB +: pmx_pkg::GENE_BITS]),
                     VW'(req_tdata[pmx_pkg::REQ_P1_LSB +: pmx_pkg::GENE_BITS])};
      par_rd_en   = 1'b0;
      par_rd_addr = k_ff;
      chd_rd_en   = 1'b0;
      chd_rd_addr = k_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == pmx_pkg::KIND_LOAD) begin
                  // A load after a closed one starts new vectors at position 0.
                  count_in  = cnt_eff;
                  closed_in = req_tlast;
                  if (cnt_eff < CW'(GENE_COUNT)) begin
                     par_wr_en = 1'b1;
                     count_in  = cnt_eff + CW'(1);
                  end
               end else if (count_ff != '0) begin
                  len_m1_in     = AW'(count_ff - CW'(1));
                  j_in          = AW'(lo_w);
                  hi_in         = AW'(hi_w);
                  first_pass_in = 1'b1;
                  state_in      = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            par_rd_en   = 1'b1;
            par_rd_addr = j_ff;
            state_in    = ST_LATCH;
         end
         ST_LATCH: begin
            p1_in    = par_rd_data[VW-1:0];
            p2_in    = par_rd_data[2*VW-1:VW];
            k_in     = '0;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            par_rd_en    = first_pass_ff;
            chd_rd_en    = !first_pass_ff;
            pend_in      = 1'b1;
            pend_addr_in = k_ff;
            pend_src_in  = first_pass_ff;
            if (k_ff == len_m1_ff) begin
               if (j_ff == hi_ff) begin
                  state_in = ST_FLUSH;
               end else begin
                  j_in          = j_ff + AW'(1);
                  first_pass_in = 1'b0;
                  state_in      = ST_FETCH;
               end
            end else begin
               k_in = k_ff + AW'(1);
            end
         end
         ST_FLUSH: begin
            // The last write-back lands here, before the read-out starts.
            k_in       = '0;
            dvalid_in  = 1'b0;
            rd_done_in = 1'b0;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (take) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = (dpos_ff == len_m1_ff);
               rsp_data_in  = '0;
               rsp_data_in[pmx_pkg::RSP_C1_LSB +: pmx_pkg::GENE_BITS] =
                  pmx_pkg::GENE_BITS'(chd_rd_data[VW-1:0]);
               rsp_data_in[pmx_pkg::RSP_C2_LSB +: pmx_pkg::GENE_BITS] =
                  pmx_pkg::GENE_BITS'(chd_rd_data[2*VW-1:VW]);
               rsp_data_in[pmx_pkg::RSP_POS_LSB +: pmx_pkg::POS_BITS] =
                  pmx_pkg::POS_BITS'(dpos_ff);
               if (dpos_ff == len_m1_ff) begin
                  state_in = ST_IDLE;
               end
            end
            if (issue) begin
               chd_rd_en = 1'b1;
               dvalid_in = 1'b1;
               dpos_in   = k_ff;
               if (k_ff == len_m1_ff) begin
                  rd_done_in = 1'b1;
               end else begin
                  k_in = k_ff + AW'(1);
               end
            end else if (take) begin
               dvalid_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      len_m1_ff    <= len_m1_in;
      j_ff         <= j_in;
      hi_ff        <= hi_in;
      k_ff         <= k_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      pend_addr_ff <= pend_addr_in;
      pend_src_ff  <= pend_src_in;
      dpos_ff      <= dpos_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_data_ff  <= rsp_data_in;
      first_pass_ff <= first_pass_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         closed_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         dvalid_ff    <= 1'b0;
         rd_done_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         closed_ff    <= closed_in;
         pend_ff      <= pend_in;
         dvalid_ff    <= dvalid_in;
         rd_done_ff   <= rd_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

>>> src/pmx_checker.sv
// ----------------------------------------------------------------------------
// PMX port checker
// Watches the ports of the crossover block: held results, the order of the
// emitted positions, and that a load leaves the block ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pmx_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tuser,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [pmx_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic                              rsp_tlast,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready
);

   logic [pmx_pkg::POS_BITS-1:0] prev_pos_ff;
   logic                         prev_last_ff;
   logic [pmx_pkg::POS_BITS-1:0] rsp_pos;
   logic [pmx_pkg::POS_BITS-1:0] exp_pos;

   assign rsp_pos = rsp_tdata[pmx_pkg::RSP_POS_LSB +: pmx_pkg::POS_BITS];
   assign exp_pos = prev_last_ff ? '0 : prev_pos_ff + pmx_pkg::POS_BITS'(1);

   // The first item of every run starts at position zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_last_ff <= 1'b1;
         prev_pos_ff  <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         prev_last_ff <= rsp_tlast;
         prev_pos_ff  <= rsp_pos;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   a_pos_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |-> rsp_pos == exp_pos)
      else $error("result positions out of order");

   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == pmx_pkg::KIND_LOAD |=> req_tready)
      else $error("block not ready after a load item");

endmodule

bind partially_matched_crossover pmx_checker u_pmx_checker (.*);

`default_nettype wire

>>> sim/tb_partially_matched_crossover.sv
// ----------------------------------------------------------------------------
// Partially matched crossover testbench
// Streams parent gene pairs and run items into the block and predicts both
// children of every run in the testbench itself. Each result item is checked
// field by field against the oldest prediction. Both stream sides idle at
// random, and the sink holds off for a long stretch once so that the block
// fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_partially_matched_crossover;

   localparam int GENE_DEPTH    = 32;
   localparam int ITEM_TARGET   = 270;
   localparam int SETTLE_CYCLES = 64;
   localparam int STALL_LIMIT   = 20000;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      logic [pmx_pkg::GENE_BITS-1:0] c1;
      logic [pmx_pkg::GENE_BITS-1:0] c2;
      logic [pmx_pkg::POS_BITS-1:0]  pos;
      logic                          last;
   } child_pair_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   // parent1_gene, parent2_gene, cut_first, cut_second
   logic [pmx_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   // kind
   logic                              req_tuser = pmx_pkg::KIND_LOAD;
   logic                              req_tlast = 1'b0;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   // child1_gene, child2_gene, position
   logic [pmx_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                              rsp_tlast;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;

   // Predictor state: parent copies, pairs held and whether the load is closed.
   logic [pmx_pkg::GENE_BITS-1:0] par1_copy [GENE_DEPTH];
   logic [pmx_pkg::GENE_BITS-1:0] par2_copy [GENE_DEPTH];
   int                            held_pairs = 0;
   bit                            load_done = 1'b0;

   child_pair_type child_pairs_due [$];
   int             mismatches = 0;
   int             items_sent = 0;
   int             stall_cycles = 0;
   bit             src_no_idle = 1'b0;
   bit             sink_no_idle = 1'b0;
   int             sink_hold_len = 0;

   partially_matched_crossover #(
      .GENE_COUNT(GENE_DEPTH),
      .VALUE_BITS(pmx_pkg::GENE_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [pmx_pkg::GENE_BITS-1:0] exchange_gene(
      input logic [pmx_pkg::GENE_BITS-1:0] g,
      input logic [pmx_pkg::GENE_BITS-1:0] from,
      input logic [pmx_pkg::GENE_BITS-1:0] to);
      if (g == from) return to;
      if (g == to) return from;
      return g;
   endfunction

   // Updates the load state, or for a run item queues both children.
   function automatic void predict_crossover(
      input logic                           kind,
      input logic [pmx_pkg::GENE_BITS-1:0]  g1,
      input logic [pmx_pkg::GENE_BITS-1:0]  g2,
      input logic                           last,
      input logic [pmx_pkg::CUT_BITS-1:0]   cut_a,
      input logic [pmx_pkg::CUT_BITS-1:0]   cut_b);
      int lo;
      int hi;
      int t;
      logic [pmx_pkg::GENE_BITS-1:0] ch1 [GENE_DEPTH];
      logic [pmx_pkg::GENE_BITS-1:0] ch2 [GENE_DEPTH];
      if (kind == pmx_pkg::KIND_LOAD) begin
         if (load_done) begin
            held_pairs = 0;
            load_done = 1'b0;
         end
         if (held_pairs < GENE_DEPTH) begin
            par1_copy[held_pairs] = g1;
            par2_copy[held_pairs] = g2;
            held_pairs++;
         end
         if (last) load_done = 1'b1;
         return;
      end
      if (held_pairs == 0) return;
      lo = cut_a;
      hi = cut_b;
      if (lo > hi) begin
         t = lo;
         lo = hi;
         hi = t;
      end
      if (lo > held_pairs - 1) lo = held_pairs - 1;
      if (hi > held_pairs - 1) hi = held_pairs - 1;
      for (int k = 0; k < held_pairs; k++) begin
         ch1[k] = par1_copy[k];
         ch2[k] = par2_copy[k];
      end
      for (int j = lo; j <= hi; j++) begin
         for (int k = 0; k < held_pairs; k++) begin
            ch1[k] = exchange_gene(ch1[k], par1_copy[j], par2_copy[j]);
            ch2[k] = exchange_gene(ch2[k], par1_copy[j], par2_copy[j]);
         end
      end
      for (int k = 0; k < held_pairs; k++)
         child_pairs_due.push_back('{ch1[k], ch2[k], pmx_pkg::POS_BITS'(k),
                                     (k == held_pairs - 1)});
   endfunction

   // Offers one item after a random gap and returns at the edge that takes it.
   task automatic send_item(input logic                          kind,
                            input logic [pmx_pkg::GENE_BITS-1:0] g1,
                            input logic [pmx_pkg::GENE_BITS-1:0] g2,
                            input logic                          last,
                            input logic [pmx_pkg::CUT_BITS-1:0]  cut_a,
                            input logic [pmx_pkg::CUT_BITS-1:0]  cut_b);
      int gap;
      logic [pmx_pkg::REQ_DATA_BITS-1:0] word;
      gap = src_no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      word = '0;
      word[pmx_pkg::REQ_P1_LSB +: pmx_pkg::GENE_BITS] = g1;
      word[pmx_pkg::REQ_P2_LSB +: pmx_pkg::GENE_BITS] = g2;
      word[pmx_pkg::REQ_CUTA_LSB +: pmx_pkg::CUT_BITS] = cut_a;
      word[pmx_pkg::REQ_CUTB_LSB +: pmx_pkg::CUT_BITS] = cut_b;
      req_tdata <= word;
      req_tuser <= kind;
      req_tlast <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_crossover(kind, g1, g2, last, cut_a, cut_b);
      items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (child_pairs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Loads len pairs. Half of the vectors are permutations of one value set,
   // which is where the remapping chains get long.
   task automatic load_parents(input int len, input bit close);
      int style;
      int j;
      logic [pmx_pkg::GENE_BITS-1:0] v1 [64];
      logic [pmx_pkg::GENE_BITS-1:0] v2 [64];
      logic [pmx_pkg::GENE_BITS-1:0] t;
      logic [pmx_pkg::GENE_BITS-1:0] base;
      style = $urandom_range(0, 3);
      base = 8'($urandom);
      for (int k = 0; k < len; k++) begin
         unique case (style)
            0, 1: begin
               v1[k] = base + 8'(k);
               v2[k] = base + 8'(k);
            end
            2: begin
               v1[k] = 8'($urandom);
               v2[k] = 8'($urandom);
            end
            default: begin
               v1[k] = base ^ 8'($urandom_range(0, 3));
               v2[k] = base ^ 8'($urandom_range(0, 3));
            end
         endcase
      end
      for (int i = len - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = v1[i];
         v1[i] = v1[j];
         v1[j] = t;
         j = $urandom_range(0, i);
         t = v2[i];
         v2[i] = v2[j];
         v2[j] = t;
      end
      for (int k = 0; k < len; k++)
         send_item(pmx_pkg::KIND_LOAD, v1[k], v2[k], close && (k == len - 1),
                   5'($urandom), 5'($urandom));
   endtask

   task automatic send_run();
      int lim;
      logic [pmx_pkg::CUT_BITS-1:0] ca;
      logic [pmx_pkg::CUT_BITS-1:0] cb;
      lim = (held_pairs == 0) ? 31 : held_pairs - 1;
      if ($urandom_range(0, 3) == 0) begin
         ca = 5'($urandom);
         cb = 5'($urandom);
      end else begin
         ca = 5'($urandom_range(0, lim));
         cb = 5'($urandom_range(0, lim));
      end
      send_item(pmx_pkg::KIND_RUN, 8'($urandom), 8'($urandom), 1'($urandom), ca, cb);
   endtask

   task automatic test_empty_run();
      send_item(pmx_pkg::KIND_RUN, 8'hA5, 8'h5A, 1'b1, 5'd31, 5'd0);
      drain_results();
   endtask

   // Extreme genes and cuts that must be swapped and saturated.
   task automatic test_extremes();
      send_item(pmx_pkg::KIND_LOAD, 8'h00, 8'hFF, 1'b0, 5'd31, 5'd31);
      send_item(pmx_pkg::KIND_LOAD, 8'hFF, 8'h00, 1'b1, 5'd0, 5'd0);
      send_item(pmx_pkg::KIND_RUN, 8'hFF, 8'hFF, 1'b0, 5'd0, 5'd31);
      send_item(pmx_pkg::KIND_RUN, 8'h00, 8'h00, 1'b1, 5'd31, 5'd31);
      send_item(pmx_pkg::KIND_RUN, 8'hFF, 8'h00, 1'b0, 5'd31, 5'd0);
      drain_results();
   endtask

   // A run on an open load, appending after it, then restarting after a close.
   task automatic test_open_load();
      send_item(pmx_pkg::KIND_LOAD, 8'h01, 8'h02, 1'b0, 5'd0, 5'd0);
      send_item(pmx_pkg::KIND_RUN, 8'h00, 8'h00, 1'b0, 5'd0, 5'd0);
      send_item(pmx_pkg::KIND_LOAD, 8'h02, 8'h01, 1'b0, 5'd0, 5'd0);
      send_item(pmx_pkg::KIND_LOAD, 8'h03, 8'h04, 1'b1, 5'd0, 5'd0);
      send_item(pmx_pkg::KIND_RUN, 8'h00, 8'h00, 1'b0, 5'd2, 5'd0);
      send_item(pmx_pkg::KIND_LOAD, 8'h80, 8'h7F, 1'b1, 5'd0, 5'd0);
      send_item(pmx_pkg::KIND_RUN, 8'h00, 8'h00, 1'b0, 5'd1, 5'd0);
      drain_results();
   endtask

   task automatic test_pmx_permutation();
      logic [pmx_pkg::GENE_BITS-1:0] p1 [5];
      logic [pmx_pkg::GENE_BITS-1:0] p2 [5];
      p1 = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5};
      p2 = '{8'd3, 8'd5, 8'd1, 8'd2, 8'd4};
      for (int k = 0; k < 5; k++)
         send_item(pmx_pkg::KIND_LOAD, p1[k], p2[k], (k == 4), 5'd0, 5'd0);
      send_item(pmx_pkg::KIND_RUN, 8'h00, 8'h00, 1'b0, 5'd1, 5'd3);
      drain_results();
   endtask

   // One pair past the store depth: dropped, but its last_gene closes the load.
   task automatic test_store_full();
      load_parents(GENE_DEPTH + 1, 1'b1);
      send_item(pmx_pkg::KIND_RUN, 8'h00, 8'h00, 1'b0, 5'd31, 5'd0);
      send_run();
      load_parents(2, 1'b1);
      send_run();
      drain_results();
   endtask

   // The sink holds off while the source keeps offering items.
   task automatic test_output_stall();
      src_no_idle = 1'b1;
      sink_hold_len = 300;
      load_parents(6, 1'b1);
      send_run();
      send_run();
      load_parents(3, 1'b1);
      send_run();
      src_no_idle = 1'b0;
      drain_results();
   endtask

   task automatic test_random_sequences();
      int style;
      int len;
      while (items_sent < ITEM_TARGET) begin
         src_no_idle = ($urandom_range(0, 5) == 0);
         sink_no_idle = ($urandom_range(0, 5) == 0);
         style = $urandom_range(0, 9);
         if (style < 8) begin
            if ($urandom_range(0, 11) == 0) len = $urandom_range(9, GENE_DEPTH + 2);
            else len = $urandom_range(1, 8);
            load_parents(len, 1'b1);
            repeat ($urandom_range(1, 2)) send_run();
         end else if (style == 8) begin
            load_parents($urandom_range(1, 4), 1'b0);
            send_run();
         end else begin
            repeat ($urandom_range(1, 3))
               send_item(1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                         5'($urandom), 5'($urandom));
         end
      end
      src_no_idle = 1'b0;
      sink_no_idle = 1'b0;
   endtask

   // Result sink: a random wait before each result item, or a long hold.
   initial begin : result_sink
      int gap;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (sink_hold_len > 0) begin
            rsp_tready <= 1'b0;
            repeat (sink_hold_len) @(posedge clock);
            sink_hold_len = 0;
            gap = 0;
         end else begin
            gap = sink_no_idle ? 0 : $urandom_range(0, 10);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         forever begin
            @(posedge clock);
            if (rsp_tvalid && rsp_tready) break;
            if (sink_hold_len > 0) break;
         end
      end
   end

   always @(posedge clock) begin : result_check
      child_pair_type want;
      logic [pmx_pkg::GENE_BITS-1:0] got_c1;
      logic [pmx_pkg::GENE_BITS-1:0] got_c2;
      logic [pmx_pkg::POS_BITS-1:0]  got_pos;
      got_c1 = rsp_tdata[pmx_pkg::RSP_C1_LSB +: pmx_pkg::GENE_BITS];
      got_c2 = rsp_tdata[pmx_pkg::RSP_C2_LSB +: pmx_pkg::GENE_BITS];
      got_pos = rsp_tdata[pmx_pkg::RSP_POS_LSB +: pmx_pkg::POS_BITS];
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (child_pairs_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result item: c1=%h c2=%h pos=%0d last=%b",
                        got_c1, got_c2, got_pos, rsp_tlast);
         end else begin
            want = child_pairs_due.pop_front();
            if (got_c1 !== want.c1 || got_c2 !== want.c2 || got_pos !== want.pos ||
                rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("result item mismatch: expected c1=%h c2=%h pos=%0d last=%b",
                           want.c1, want.c2, want.pos, want.last);
                  $display("                      got      c1=%h c2=%h pos=%0d last=%b",
                           got_c1, got_c2, got_pos, rsp_tlast);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : main
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_run();
      test_extremes();
      test_open_load();
      test_pmx_permutation();
      test_store_full();
      test_output_stall();
      test_random_sequences();
      drain_results();
      if (mismatches == 0 && child_pairs_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> partially_matched_crossover.f
src/pmx_pkg.sv
src/pmx_ram.sv
src/partially_matched_crossover.sv
src/pmx_checker.sv
sim/tb_partially_matched_crossover.sv
